FILE: hdl/aipap_pkg.sv
package aipap_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_SOURCE_FORMAT     = 2'd0,
		CFG_CHANNELS_CODE     = 2'd1,
		CFG_FIRST_CHANNEL_ID  = 2'd2,
		CFG_FRAMES_PER_PACKET = 2'd3
	} cfg_index_t;

	localparam int CFG_DATA_W = 14;

	// Source layouts.
	localparam logic [3:0] FMT_S16LE      = 4'd0;
	localparam logic [3:0] FMT_S16BE      = 4'd1;
	localparam logic [3:0] FMT_S24LE      = 4'd2;
	localparam logic [3:0] FMT_S24BE      = 4'd3;
	localparam logic [3:0] FMT_S32LE      = 4'd4;
	localparam logic [3:0] FMT_S32BE      = 4'd5;
	localparam logic [3:0] FMT_S24LE_HI32 = 4'd6;
	localparam logic [3:0] FMT_S24LE_LO32 = 4'd7;
	localparam logic [3:0] FMT_S24BE_HI32 = 4'd8;
	localparam logic [3:0] FMT_S24BE_LO32 = 4'd9;

	// Bits code carried in the fourth header byte.
	localparam logic [1:0] BITS_CODE_16 = 2'd0;
	localparam logic [1:0] BITS_CODE_24 = 2'd2;

	// Channel status block length in frames.
	localparam int         BLOCK_LEN      = 192;
	localparam logic [7:0] PHASE_LAST     = 8'(BLOCK_LEN - 1);

	// Stream widths.
	localparam int HDR_BYTES  = 4;
	localparam int DATA_BYTES = 5;
	localparam int STREAM_W   = 28;
	localparam int ABYTES_W   = 19;

	// Depth of the queue between front and back end.
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [31:0] sample_bytes;
		logic [2:0]  vuc_bits;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       packet_end;
		logic       size_error;
	} out_beat_t;

	// One classified item, as handed from the front end to the back end.
	typedef struct packed {
		logic                            size_error;
		logic                            header;
		logic [HDR_BYTES-1:0][7:0]       hdr_bytes;
		logic [DATA_BYTES-1:0][7:0]      data_bytes;
		logic [2:0]                      data_count;
		logic                            pkt_end;
	} item_t;

endpackage

FILE: hdl/aes3_in_pes_audio_packer.sv
// Channel | Direction | Handshake               | Beat
// --------+-----------+-------------------------+----------------------------------------
// in      | input     | in_valid / in_stall     | in_beat_t: sample_bytes, vuc_bits
// out     | output    | out_valid / out_stall   | out_beat_t: out_byte, last, packet_end,
//         |           |                         |   size_error
// cfg     | input     | cfg_we (write only)     | cfg_index, cfg_data
//
// The back end sends one byte per cycle while out_stall is low; an input beat
// yields 2 or 3 (16-bit) or 3 or 4 (24-bit) data bytes, plus 4 header bytes on the
// first beat of a packet and one flush byte at packet end. A size error beat yields
// a single byte.
// An input beat is accepted in the cycle it arrives while the four-entry queue has
// room; its first output byte passes the queue entry and then the output register.
// Reset clears the configuration to its defaults and all packing state at once.
// A stall on the output fills the queue, after which in_stall rises.
module aes3_in_pes_audio_packer import aipap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_data
);

	// The front end classifies each beat: it decides on the header, merges the new
	// bits into the pending partial byte and, for a beat without a size error,
	// updates the channel, frame and block counters in the cycle of acceptance.
	logic  push;
	logic  queue_full;
	item_t push_item;

	// The back end walks through the bytes of the item at the head of the queue.
	logic  pop;
	logic  head_valid;
	item_t head_item;

	aipap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.queue_full (queue_full),
		.in_stall   (in_stall),
		.push       (push),
		.item       (push_item)
	);

	aipap_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	aipap_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

FILE: hdl/aipap_front.sv
module aipap_front import aipap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  in_beat_t              in_data,
	input  logic                  queue_full,
	output logic                  in_stall,
	output logic                  push,
	output item_t                 item
);

	logic [3:0]  source_format_q;
	logic [1:0]  channels_code_q;
	logic [7:0]  first_channel_id_q;
	logic [13:0] frames_per_packet_q;

	logic [7:0]  block_phase_q;
	logic [2:0]  channel_index_q;
	logic [13:0] frame_index_q;
	logic [7:0]  partial_q;
	logic [2:0]  bit_position_q;

	logic                 is16;
	logic [2:0]           unit_bytes;
	logic [2:0]           ch_pairs;
	logic [4:0]           per_frame;
	logic [13:0]          frames;
	logic [ABYTES_W-1:0]  audio_bytes;
	logic                 size_err;
	logic [2:0]           ch_last_idx;
	logic                 ch_last;
	logic                 pkt_end;
	logic                 header;
	logic [23:0]          sample;
	logic [STREAM_W-1:0]  stream;
	logic [STREAM_W-1:0]  stream_rev;
	logic [39:0]          merged;
	logic [2:0]           bp_eff;
	logic [7:0]           partial_eff;
	logic [5:0]           total_bits;
	logic [2:0]           full_bytes;
	logic                 flush;
	logic [7:0]           partial_d;
	logic [2:0]           bit_position_d;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q     <= FMT_S16LE;
			channels_code_q     <= 2'd0;
			first_channel_id_q  <= 8'd0;
			frames_per_packet_q <= 14'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE_FORMAT:     source_format_q     <= cfg_data[3:0];
				CFG_CHANNELS_CODE:     channels_code_q     <= cfg_data[1:0];
				CFG_FIRST_CHANNEL_ID:  first_channel_id_q  <= cfg_data[7:0];
				CFG_FRAMES_PER_PACKET: frames_per_packet_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// Sample extraction per source layout.
	always_comb begin
		case (source_format_q) inside
			FMT_S16LE:
				sample = {8'd0, in_data.sample_bytes[15:8], in_data.sample_bytes[7:0]};
			FMT_S16BE:
				sample = {8'd0, in_data.sample_bytes[7:0], in_data.sample_bytes[15:8]};
			FMT_S24LE, FMT_S24LE_LO32:
				sample = in_data.sample_bytes[23:0];
			FMT_S24BE, FMT_S32BE, FMT_S24BE_HI32:
				sample = {in_data.sample_bytes[7:0], in_data.sample_bytes[15:8],
					in_data.sample_bytes[23:16]};
			FMT_S32LE, FMT_S24LE_HI32:
				sample = in_data.sample_bytes[31:8];
			FMT_S24BE_LO32:
				sample = {in_data.sample_bytes[15:8], in_data.sample_bytes[23:16],
					in_data.sample_bytes[31:24]};
			default:
				sample = 24'd0;
		endcase
	end

	always_comb begin
		is16        = (source_format_q <= FMT_S16BE);
		unit_bytes  = is16 ? 3'd5 : 3'd7;
		ch_pairs    = {1'b0, channels_code_q} + 3'd1;
		per_frame   = 5'(unit_bytes) * 5'(ch_pairs);
		frames      = (frames_per_packet_q == 14'd0) ? 14'd1 : frames_per_packet_q;
		audio_bytes = ABYTES_W'(per_frame) * ABYTES_W'(frames);
		size_err    = (audio_bytes[ABYTES_W-1:16] != '0);
		ch_last_idx = {channels_code_q, 1'b1};
		ch_last     = (channel_index_q >= ch_last_idx);
		pkt_end     = ch_last && (frame_index_q >= (frames - 14'd1));
		header      = (frame_index_q == 14'd0) && (channel_index_q == 3'd0);

		// Bits in transmission order, first bit at index zero.
		if (is16) begin
			stream = {8'd0, (block_phase_q == 8'd0), in_data.vuc_bits, sample[15:0]};
		end else begin
			stream = {(block_phase_q == 8'd0), in_data.vuc_bits, sample};
		end
		for (int i = 0; i < STREAM_W; i++) begin
			stream_rev[STREAM_W-1-i] = stream[i];
		end

		bp_eff      = header ? 3'd0 : bit_position_q;
		partial_eff = header ? 8'd0 : partial_q;
		merged      = {partial_eff, 32'd0} | ({stream_rev, 12'd0} >> bp_eff);
		total_bits  = 6'(bp_eff) + (is16 ? 6'd20 : 6'd28);
		full_bytes  = total_bits[5:3];
		flush       = pkt_end && (total_bits[2:0] != 3'd0);

		item.size_error = size_err;
		item.header     = header;
		item.hdr_bytes[0] = audio_bytes[15:8];
		item.hdr_bytes[1] = audio_bytes[7:0];
		item.hdr_bytes[2] = {channels_code_q, first_channel_id_q[7:2]};
		item.hdr_bytes[3] = {first_channel_id_q[1:0], is16 ? BITS_CODE_16 : BITS_CODE_24,
			4'd0};
		for (int k = 0; k < DATA_BYTES; k++) begin
			item.data_bytes[k] = merged[39-8*k -: 8];
		end
		item.data_count = full_bytes + 3'(flush);
		item.pkt_end    = pkt_end;

		case (full_bytes)
			3'd0:    partial_d = merged[39:32];
			3'd1:    partial_d = merged[31:24];
			3'd2:    partial_d = merged[23:16];
			3'd3:    partial_d = merged[15:8];
			3'd4:    partial_d = merged[7:0];
			default: partial_d = 8'd0;
		endcase
		if (flush) begin
			partial_d = 8'd0;
		end
		bit_position_d = flush ? 3'd0 : total_bits[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_phase_q   <= 8'd0;
			channel_index_q <= 3'd0;
			frame_index_q   <= 14'd0;
			partial_q       <= 8'd0;
			bit_position_q  <= 3'd0;
		end else if (push && !size_err) begin
			partial_q      <= partial_d;
			bit_position_q <= bit_position_d;
			if (ch_last) begin
				channel_index_q <= 3'd0;
				block_phase_q   <= (block_phase_q >= PHASE_LAST) ? 8'd0 : block_phase_q + 8'd1;
				frame_index_q   <= pkt_end ? 14'd0 : frame_index_q + 14'd1;
			end else begin
				channel_index_q <= channel_index_q + 3'd1;
			end
		end
	end

	// Only the leading bit_position bits of the partial byte may be set.
	a_partial_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(partial_q & (8'hFF >> bit_position_q)) == 8'd0)
		else $error("partial byte holds bits beyond its fill level");

endmodule

FILE: hdl/aipap_fifo.sv
module aipap_fifo import aipap_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output item_t head_item
);

	item_t               entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	assign full       = (count_q == QCOUNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCOUNT_W'(push) - QCOUNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");

endmodule

FILE: hdl/aipap_back.sv
module aipap_back import aipap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  item_t     head_item,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	out_beat_t  out_data_s1;

	logic [3:0] last_idx;
	logic       is_last;
	logic       advance;
	logic [2:0] data_idx;
	logic [7:0] byte_sel;

	always_comb begin
		if (head_item.size_error) begin
			last_idx = 4'd0;
		end else begin
			last_idx = (head_item.header ? 4'(HDR_BYTES) : 4'd0)
				+ 4'(head_item.data_count) - 4'd1;
		end
		is_last  = ({1'b0, idx_q} == last_idx);
		advance  = head_valid && (!out_valid_q || !out_stall);
		pop      = advance && is_last;
		data_idx = head_item.header ? idx_q - 3'(HDR_BYTES) : idx_q;

		case (data_idx)
			3'd0:    byte_sel = head_item.data_bytes[0];
			3'd1:    byte_sel = head_item.data_bytes[1];
			3'd2:    byte_sel = head_item.data_bytes[2];
			3'd3:    byte_sel = head_item.data_bytes[3];
			3'd4:    byte_sel = head_item.data_bytes[4];
			default: byte_sel = 8'd0;
		endcase
		if (head_item.size_error) begin
			byte_sel = 8'd0;
		end else if (head_item.header && idx_q < 3'(HDR_BYTES)) begin
			byte_sel = head_item.hdr_bytes[idx_q[1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s1.out_byte   <= byte_sel;
			out_data_s1.last       <= is_last;
			out_data_s1.packet_end <= is_last && head_item.pkt_end && !head_item.size_error;
			out_data_s1.size_error <= head_item.size_error;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_s1;

	a_mid_item_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> head_valid)
		else $error("item left the queue before all its beats were sent");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_s1.size_error |-> out_data_s1.last
			&& !out_data_s1.packet_end)
		else $error("size error beat is not a lone final beat");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_s1.packet_end |-> out_data_s1.last)
		else $error("packet end flagged on a beat that is not the last of its item");

endmodule

FILE: tb/tb_aes3_in_pes_audio_packer.sv
module tb_aes3_in_pes_audio_packer;
	import aipap_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Generous cycle budget for a run of a few hundred beats, even with the
	// heaviest output stalls.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_BEATS  = 270;
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_LIMIT  = 30;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	cfg_index_t            cfg_index = CFG_SOURCE_FORMAT;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_beat_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_beat_t             out_data;

	aes3_in_pes_audio_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Shadow copy of the configuration registers, updated as each write is issued.
	logic [3:0]  fmt_cfg    = FMT_S16LE;
	logic [1:0]  chan_code  = 2'd0;
	logic [7:0]  chan_id    = 8'd0;
	logic [13:0] frames_cfg = 14'd1;

	// Packing state of the predictor.
	logic [7:0]  block_phase = 8'd0;
	logic [2:0]  chan_slot   = 3'd0;
	logic [13:0] frame_idx   = 14'd0;
	logic [7:0]  part_byte   = 8'd0;
	logic [2:0]  bit_pos     = 3'd0;

	in_beat_t  pending_beats[$];
	out_beat_t bytes_due[$];

	int cycle_count = 0;
	int mismatches  = 0;

	function automatic out_beat_t payload_byte(input logic [7:0] value);
		out_beat_t b;
		b            = '0;
		b.out_byte   = value;
		return b;
	endfunction

	// Works out the bytes that one accepted sample beat produces and queues them.
	task automatic pack_sample(input in_beat_t beat);
		out_beat_t   produced[$];
		out_beat_t   flagged;
		logic [7:0]  b0, b1, b2, b3;
		logic [23:0] sample;
		logic [27:0] stream;
		logic [1:0]  bits_code;
		bit          is16, ch_last, pkt_end;
		int          nbits, nch, nframes, per_frame, audio_bytes;

		is16        = (fmt_cfg <= FMT_S16BE);
		nbits       = is16 ? 16 : 24;
		bits_code   = is16 ? BITS_CODE_16 : BITS_CODE_24;
		nch         = 2 * (int'(chan_code) + 1);
		nframes     = (frames_cfg == 0) ? 1 : int'(frames_cfg);
		per_frame   = ((nbits + 4) * nch + 7) / 8;
		audio_bytes = per_frame * nframes;

		// A packet too large for the 16-bit byte count yields a single flagged beat
		// and leaves the packing state alone.
		if (audio_bytes > 65535) begin
			flagged            = '0;
			flagged.last       = 1'b1;
			flagged.size_error = 1'b1;
			bytes_due.push_back(flagged);
			return;
		end

		// The first sample of a packet is preceded by the four header bytes; any
		// bits left over from before are thrown away.
		if (frame_idx == 0 && chan_slot == 0) begin
			part_byte = 8'd0;
			bit_pos   = 3'd0;
			produced.push_back(payload_byte(8'(audio_bytes >> 8)));
			produced.push_back(payload_byte(8'(audio_bytes)));
			produced.push_back(payload_byte({chan_code, chan_id[7:2]}));
			produced.push_back(payload_byte({chan_id[1:0], bits_code, 4'b0000}));
		end

		b0 = beat.sample_bytes[7:0];
		b1 = beat.sample_bytes[15:8];
		b2 = beat.sample_bytes[23:16];
		b3 = beat.sample_bytes[31:24];
		case (fmt_cfg)
			FMT_S16LE:                       sample = {8'd0, b1, b0};
			FMT_S16BE:                       sample = {8'd0, b0, b1};
			FMT_S24LE, FMT_S24LE_LO32:       sample = {b2, b1, b0};
			FMT_S24BE, FMT_S32BE,
			FMT_S24BE_HI32:                  sample = {b0, b1, b2};
			FMT_S32LE, FMT_S24LE_HI32:       sample = {b3, b2, b1};
			FMT_S24BE_LO32:                  sample = {b1, b2, b3};
			default:                         sample = 24'd0;
		endcase

		// The subframe goes out LSB first: sample bits, then V, U, C and F.
		stream = 28'(sample);
		stream = stream | (28'(beat.vuc_bits) << nbits);
		if (block_phase == 0)
			stream[nbits + 3] = 1'b1;
		for (int i = 0; i < nbits + 4; i++) begin
			if (stream[i])
				part_byte[3'd7 - bit_pos] = 1'b1;
			bit_pos = bit_pos + 3'd1;
			if (bit_pos == 0) begin
				produced.push_back(payload_byte(part_byte));
				part_byte = 8'd0;
			end
		end

		// A slot at or beyond the last channel closes the frame, and a frame at or
		// beyond the last frame of the packet closes the packet.
		ch_last = (int'(chan_slot) >= nch - 1);
		pkt_end = ch_last && (int'(frame_idx) >= nframes - 1);

		if (pkt_end && bit_pos != 0) begin
			produced.push_back(payload_byte(part_byte));
			part_byte = 8'd0;
			bit_pos   = 3'd0;
		end

		if (ch_last) begin
			chan_slot   = 3'd0;
			block_phase = (block_phase >= PHASE_LAST) ? 8'd0 : block_phase + 8'd1;
			frame_idx   = pkt_end ? 14'd0 : frame_idx + 14'd1;
		end else begin
			chan_slot = chan_slot + 3'd1;
		end

		produced[$].last = 1'b1;
		if (pkt_end)
			produced[$].packet_end = 1'b1;
		foreach (produced[i])
			bytes_due.push_back(produced[i]);
	endtask

	// Sender: bursts of random length separated by random gaps. A stalled beat is
	// held unchanged, and valid is only lowered once the beat has gone.
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && !in_stall)
				pack_sample(in_data);

			if (in_valid && in_stall) begin
				// Hold the beat until the block takes it.
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				in_data  <= pending_beats.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
					                                         : $urandom_range(0, 4);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: the stall behaviour changes every so often between never stalling,
	// light random stalls, a fixed rhythm and heavy random stalls.
	int stall_mode = 0;
	int mode_left  = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = 0;
			mode_left  = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 3) == 0);
				2:       out_stall <= ((cycle_count % 7) < 3);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Every byte the block hands over is checked against the oldest one due.
	out_beat_t due_beat;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected output beat %p", $time, out_data);
			end else begin
				due_beat = bytes_due.pop_front();
				if (out_data.out_byte !== due_beat.out_byte ||
				    out_data.last !== due_beat.last ||
				    out_data.packet_end !== due_beat.packet_end ||
				    out_data.size_error !== due_beat.size_error) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: output mismatch, expected %p, got %p",
						         $time, due_beat, out_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d bytes still due", $time, bytes_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic queue_sample(input logic [31:0] word, input logic [2:0] vuc);
		pending_beats.push_back(in_beat_t'({word, vuc}));
	endtask

	// Waits until every queued sample has been taken and every byte has come out,
	// then lets the block settle.
	task automatic wait_idle();
		while (pending_beats.size() > 0 || in_valid || bytes_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		case (idx)
			CFG_SOURCE_FORMAT:     fmt_cfg    = 4'(value);
			CFG_CHANNELS_CODE:     chan_code  = 2'(value);
			CFG_FIRST_CHANNEL_ID:  chan_id    = 8'(value);
			CFG_FRAMES_PER_PACKET: frames_cfg = 14'(value);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick_frames();
		int unsigned r;
		r = $urandom_range(0, 19);
		case (r)
			0:       return 0;
			1:       return 16383;
			// Around the point where the byte count overflows for 8 x 24 bit
			// and for 2 x 16 bit.
			2:       return $urandom_range(2339, 2342);
			3:       return $urandom_range(13106, 13109);
			4:       return $urandom_range(5, 300);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	int random_beats = 0;
	int phase_len;
	bit wrote_one;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: 16-bit little endian, two channels, one frame per packet,
		// with all-zero and all-one words.
		queue_sample(32'h0000_0000, 3'b000);
		queue_sample(32'hFFFF_FFFF, 3'b111);
		wait_idle();

		// One sample in each layout, the undefined codes included.
		for (int f = 1; f < 16; f++) begin
			write_reg(CFG_SOURCE_FORMAT, f);
			write_reg(CFG_FIRST_CHANNEL_ID, (f % 2) ? 8'hFF : 8'h00);
			queue_sample($urandom, 3'(f));
			wait_idle();
		end

		// Oversized packet: eight 24-bit channels and the largest frame count.
		write_reg(CFG_SOURCE_FORMAT, FMT_S24LE);
		write_reg(CFG_CHANNELS_CODE, 3);
		write_reg(CFG_FRAMES_PER_PACKET, 16383);
		queue_sample($urandom, 3'b101);
		wait_idle();

		// A frame count of zero behaves as one.
		write_reg(CFG_CHANNELS_CODE, 0);
		write_reg(CFG_FRAMES_PER_PACKET, 0);
		queue_sample($urandom, 3'b010);
		queue_sample($urandom, 3'b100);
		wait_idle();

		// Slot beyond the channel count: start six 16-bit channels, then drop to two
		// 24-bit channels so that the packet ends on a byte boundary and needs no flush.
		write_reg(CFG_SOURCE_FORMAT, FMT_S16LE);
		write_reg(CFG_CHANNELS_CODE, 2);
		repeat (3) queue_sample($urandom, 3'($urandom_range(0, 7)));
		wait_idle();
		write_reg(CFG_SOURCE_FORMAT, FMT_S24LE);
		write_reg(CFG_CHANNELS_CODE, 0);
		queue_sample($urandom, 3'b111);
		wait_idle();

		// Frame index past the packet: shrink the packet once a frame is in.
		write_reg(CFG_FRAMES_PER_PACKET, 2);
		repeat (2) queue_sample($urandom, 3'($urandom_range(0, 7)));
		wait_idle();
		write_reg(CFG_FRAMES_PER_PACKET, 1);
		repeat (2) queue_sample($urandom, 3'($urandom_range(0, 7)));
		wait_idle();

		// Random phases, with two channels the most common; each phase rewrites
		// some of the registers.
		while (random_beats < RANDOM_BEATS) begin
			wrote_one = 1'b0;
			while (!wrote_one) begin
				if ($urandom_range(0, 1)) begin
					write_reg(CFG_SOURCE_FORMAT, ($urandom_range(0, 7) == 0) ?
					          $urandom_range(10, 15) : $urandom_range(0, 9));
					wrote_one = 1'b1;
				end
				if ($urandom_range(0, 1)) begin
					write_reg(CFG_CHANNELS_CODE, ($urandom_range(0, 9) < 6) ?
					          0 : $urandom_range(1, 3));
					wrote_one = 1'b1;
				end
				if ($urandom_range(0, 2) == 0) begin
					case ($urandom_range(0, 3))
						0:       write_reg(CFG_FIRST_CHANNEL_ID, 8'h00);
						1:       write_reg(CFG_FIRST_CHANNEL_ID, 8'hFF);
						default: write_reg(CFG_FIRST_CHANNEL_ID, $urandom_range(0, 255));
					endcase
					wrote_one = 1'b1;
				end
				if ($urandom_range(0, 2) == 0) begin
					write_reg(CFG_FRAMES_PER_PACKET, pick_frames());
					wrote_one = 1'b1;
				end
			end
			phase_len = $urandom_range(4, 40);
			for (int i = 0; i < phase_len; i++)
				queue_sample($urandom, 3'($urandom_range(0, 7)));
			random_beats += phase_len;
			wait_idle();
		end

		if (mismatches == 0 && bytes_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
